### hw/rtl/rhp_pkg.sv
// rtp header parser package: descriptor and result types, field codes
package rhp_pkg;

    localparam int HDR_FIXED_BYTES = 12;
    localparam int LEN_W           = 16;
    // wide enough for 12 + 60 + 4 + 4 * 65535
    localparam int HL_W            = 19;

    localparam logic [1:0] KIND_HDR    = 2'd0;
    localparam logic [1:0] KIND_CSRC   = 2'd1;
    localparam logic [1:0] KIND_LAYOUT = 2'd2;

    localparam logic [2:0] STAT_OK            = 3'd0;
    localparam logic [2:0] STAT_SHORT         = 3'd1;
    localparam logic [2:0] STAT_CSRC_CUT      = 3'd2;
    localparam logic [2:0] STAT_EXT_HDR_CUT   = 3'd3;
    localparam logic [2:0] STAT_EXT_DATA_CUT  = 3'd4;
    localparam logic [2:0] STAT_BAD_PAD       = 3'd5;
    localparam logic [2:0] STAT_TOO_LONG      = 3'd6;

    // one parsed packet, handed from the front end to the back end
    typedef struct packed {
        logic [7:0]       b0;
        logic [7:0]       b1;
        logic [15:0]      seq;
        logic [31:0]      ts;
        logic [31:0]      ssrc;
        logic [15:0]      prof;
        logic [15:0]      ewords;
        logic [LEN_W-1:0] len;
        logic [7:0]       pad_byte;
        logic             too_long;
        logic [3:0]       nwords;
    } t_desc;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  version;
        logic        padding_flag;
        logic        extension_flag;
        logic [3:0]  csrc_count;
        logic        marker;
        logic [6:0]  payload_type;
        logic [15:0] half_field;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [2:0]  status;
        logic        last_result;
    } t_result;

endpackage

### hw/rtl/rtp_header_parser.sv
// rtp header parser: one packet byte per cycle in, header/csrc/layout items out
// input: one byte per cycle; stalls only when the packet queue or csrc word queue is full
// after the final byte, the back end sequencer steps through idle, calc1, calc2 and calc3
// before the header item shows, then sends any csrc items and last the layout item
// the back end works on each packet overlapped with input of the next packet
// reset is synchronous active low: queues empty, byte count and header fields cleared
module rtp_header_parser import rhp_pkg::*; #(
    parameter int MAX_PACKET_BYTES = 65535,
    parameter int MAX_CSRC         = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_packet,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_version,
    output logic        o_padding_flag,
    output logic        o_extension_flag,
    output logic [3:0]  o_csrc_count,
    output logic        o_marker,
    output logic [6:0]  o_payload_type,
    output logic [15:0] o_half_field,
    output logic [31:0] o_word_a,
    output logic [31:0] o_word_b,
    output logic [2:0]  o_status,
    output logic        o_last_result
);

    localparam int IDX_W   = $clog2(MAX_PACKET_BYTES + 1);
    localparam int WORD_AW = $clog2(MAX_CSRC + 1) + 1;
    localparam int DESC_AW = 1;

    logic        desc_push, desc_full, desc_pop, desc_empty;
    t_desc       desc_in, desc_out;
    logic        word_push, word_full, word_pop, word_empty;
    logic [31:0] word_in, word_out;
    t_result     res;

    rhp_front #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES),
        .MAX_CSRC         (MAX_CSRC),
        .IDX_W            (IDX_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .i_data_byte     (i_data_byte),
        .i_end_of_packet (i_end_of_packet),
        .o_stall         (o_in_stall),
        .o_desc_push     (desc_push),
        .o_desc          (desc_in),
        .i_desc_full     (desc_full),
        .o_word_push     (word_push),
        .o_word          (word_in),
        .i_word_full     (word_full)
    );

    rhp_fifo #(
        .WIDTH ($bits(t_desc)),
        .AW    (DESC_AW)
    ) u_desc_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_push),
        .i_data  (desc_in),
        .o_full  (desc_full),
        .i_pop   (desc_pop),
        .o_data  (desc_out),
        .o_empty (desc_empty)
    );

    rhp_fifo #(
        .WIDTH (32),
        .AW    (WORD_AW)
    ) u_word_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (word_push),
        .i_data  (word_in),
        .o_full  (word_full),
        .i_pop   (word_pop),
        .o_data  (word_out),
        .o_empty (word_empty)
    );

    rhp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (desc_out),
        .i_desc_empty (desc_empty),
        .o_desc_pop   (desc_pop),
        .i_word       (word_out),
        .i_word_empty (word_empty),
        .o_word_pop   (word_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_res        (res)
    );

    assign o_kind           = res.kind;
    assign o_version        = res.version;
    assign o_padding_flag   = res.padding_flag;
    assign o_extension_flag = res.extension_flag;
    assign o_csrc_count     = res.csrc_count;
    assign o_marker         = res.marker;
    assign o_payload_type   = res.payload_type;
    assign o_half_field     = res.half_field;
    assign o_word_a         = res.word_a;
    assign o_word_b         = res.word_b;
    assign o_status         = res.status;
    assign o_last_result    = res.last_result;

    a_word_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        word_push |-> !word_full)
        else $error("csrc word queue written while full");

    a_desc_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        desc_push |-> !desc_full)
        else $error("packet queue written while full");

    a_word_q_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        word_pop |-> !word_empty)
        else $error("csrc word queue read while empty");

    a_last_is_layout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_result) |-> (o_kind == KIND_LAYOUT))
        else $error("last item of a packet is not a layout item");

    a_csrc_item_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_CSRC)) |->
            (o_word_b == 32'd0 && o_half_field == 16'd0 && o_version == 2'd0))
        else $error("csrc item carries header or layout fields");

endmodule

### hw/rtl/rhp_fifo.sv
// small first-word-fall-through queue
module rhp_fifo #(
    parameter int WIDTH,
    parameter int AW
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2**AW];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;

    // count never exceeds the depth, so the top bit alone means full
    assign o_full  = r_count[AW];
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (AW+1)'(1);
                2'b01:   r_count <= r_count - (AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hw/rtl/rhp_front.sv
// front end: takes packet bytes, sorts each into its header role, queues results
module rhp_front import rhp_pkg::*; #(
    parameter int MAX_PACKET_BYTES,
    parameter int MAX_CSRC,
    parameter int IDX_W
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_packet,
    output logic        o_stall,
    output logic        o_desc_push,
    output t_desc       o_desc,
    input  logic        i_desc_full,
    output logic        o_word_push,
    output logic [31:0] o_word,
    input  logic        i_word_full
);

    localparam int CW = ((IDX_W > 7) ? IDX_W : 7) + 1;

    logic [IDX_W-1:0] r_idx, n_idx;
    logic [7:0]       r_b0, n_b0;
    logic [7:0]       r_b1, n_b1;
    logic [15:0]      r_seq, n_seq;
    logic [31:0]      r_ts, n_ts;
    logic [31:0]      r_ssrc, n_ssrc;
    logic [15:0]      r_prof, n_prof;
    logic [15:0]      r_ewords, n_ewords;
    logic [23:0]      r_word_sh, n_word_sh;
    logic [3:0]       r_nwords, n_nwords;

    logic          accept;
    logic          too_long;
    logic [CW-1:0] idx_x;
    logic [CW-1:0] hdr;
    logic [CW-1:0] pos;
    logic [3:0]    wsel;
    logic          word_done;

    assign o_stall  = i_desc_full || i_word_full;
    assign accept   = i_valid && !o_stall;
    assign too_long = (r_idx == IDX_W'(MAX_PACKET_BYTES));
    assign idx_x    = CW'(r_idx);
    assign hdr      = CW'({r_b0[3:0], 2'b00}) + CW'(HDR_FIXED_BYTES);
    assign pos      = idx_x - CW'(HDR_FIXED_BYTES);
    assign wsel     = pos[5:2];

    always_comb begin
        n_idx     = r_idx;
        n_b0      = r_b0;
        n_b1      = r_b1;
        n_seq     = r_seq;
        n_ts      = r_ts;
        n_ssrc    = r_ssrc;
        n_prof    = r_prof;
        n_ewords  = r_ewords;
        n_word_sh = r_word_sh;
        n_nwords  = r_nwords;
        word_done = 1'b0;
        if (!too_long) begin
            if (idx_x == CW'(0)) begin
                n_b0 = i_data_byte;
            end else if (idx_x == CW'(1)) begin
                n_b1 = i_data_byte;
            end else if (idx_x < CW'(4)) begin
                n_seq = {r_seq[7:0], i_data_byte};
            end else if (idx_x < CW'(8)) begin
                n_ts = {r_ts[23:0], i_data_byte};
            end else if (idx_x < CW'(HDR_FIXED_BYTES)) begin
                n_ssrc = {r_ssrc[23:0], i_data_byte};
            end else if (idx_x < hdr) begin
                // csrc words beyond the store limit are dropped, though their bytes still advance the byte index
                if ({1'b0, wsel} < 5'(MAX_CSRC)) begin
                    n_word_sh = {r_word_sh[15:0], i_data_byte};
                    if (pos[1:0] == 2'b11) begin
                        word_done = 1'b1;
                        n_nwords  = r_nwords + 4'd1;
                    end
                end
            end else if (r_b0[4] && (idx_x < hdr + CW'(4))) begin
                if (idx_x < hdr + CW'(2)) begin
                    n_prof = {r_prof[7:0], i_data_byte};
                end else begin
                    n_ewords = {r_ewords[7:0], i_data_byte};
                end
            end
            n_idx = r_idx + IDX_W'(1);
        end
    end

    assign o_word_push = accept && word_done;
    assign o_word      = {r_word_sh, i_data_byte};
    assign o_desc_push = accept && i_end_of_packet;

    always_comb begin
        o_desc.b0       = n_b0;
        o_desc.b1       = n_b1;
        o_desc.seq      = n_seq;
        o_desc.ts       = n_ts;
        o_desc.ssrc     = n_ssrc;
        o_desc.prof     = n_prof;
        o_desc.ewords   = n_ewords;
        o_desc.len      = LEN_W'(r_idx) + LEN_W'(1);
        o_desc.pad_byte = i_data_byte;
        o_desc.too_long = too_long;
        o_desc.nwords   = n_nwords;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word_sh <= n_word_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_b0     <= '0;
            r_b1     <= '0;
            r_seq    <= '0;
            r_ts     <= '0;
            r_ssrc   <= '0;
            r_prof   <= '0;
            r_ewords <= '0;
            r_nwords <= '0;
        end else if (accept) begin
            if (i_end_of_packet) begin
                r_idx    <= '0;
                r_b0     <= '0;
                r_b1     <= '0;
                r_seq    <= '0;
                r_ts     <= '0;
                r_ssrc   <= '0;
                r_prof   <= '0;
                r_ewords <= '0;
                r_nwords <= '0;
            end else begin
                r_idx    <= n_idx;
                r_b0     <= n_b0;
                r_b1     <= n_b1;
                r_seq    <= n_seq;
                r_ts     <= n_ts;
                r_ssrc   <= n_ssrc;
                r_prof   <= n_prof;
                r_ewords <= n_ewords;
                r_nwords <= n_nwords;
            end
        end
    end

endmodule

### hw/rtl/rhp_back.sv
// back end: checks one packet's layout and sends its header, csrc and layout items
module rhp_back import rhp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_desc       i_desc,
    input  logic        i_desc_empty,
    output logic        o_desc_pop,
    input  logic [31:0] i_word,
    input  logic        i_word_empty,
    output logic        o_word_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_result     o_res
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CALC1 = 7'b0000010,
        ST_CALC2 = 7'b0000100,
        ST_CALC3 = 7'b0001000,
        ST_HDR   = 7'b0010000,
        ST_CSRC  = 7'b0100000,
        ST_LAST  = 7'b1000000
    } t_bstate;

    t_bstate          r_state, n_state;
    t_desc            r_d;
    logic [2:0]       r_status;
    logic [HL_W-1:0]  r_hext;
    logic [HL_W-1:0]  r_hfin;
    logic             r_have_prof;
    logic [15:0]      r_wa;
    logic [15:0]      r_wb;
    logic [3:0]       r_left;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;

    logic            ext;
    logic            pad;
    logic [HL_W-1:0] hlen;
    logic [HL_W-1:0] len_x;
    logic [HL_W-1:0] b_x;
    logic            emit_csrc;
    logic            load_ok;
    logic            item_valid;
    t_result         item;

    assign ext     = r_d.b0[4];
    assign pad     = r_d.b0[5];
    assign hlen    = HL_W'({r_d.b0[3:0], 2'b00}) + HL_W'(HDR_FIXED_BYTES);
    assign len_x   = HL_W'(r_d.len);
    assign b_x     = HL_W'(r_d.pad_byte);
    assign load_ok = !r_out_valid || !i_out_stall;
    // packets with cut csrc words, short and over-long packets send no csrc items
    assign emit_csrc = (r_status == STAT_OK) || (r_status == STAT_EXT_HDR_CUT) ||
                       (r_status == STAT_EXT_DATA_CUT) || (r_status == STAT_BAD_PAD);

    always_comb begin
        n_state    = r_state;
        o_desc_pop = 1'b0;
        o_word_pop = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        item.status = r_status;
        case (r_state)
            ST_IDLE: begin
                if (!i_desc_empty) begin
                    o_desc_pop = 1'b1;
                    n_state    = ST_CALC1;
                end
            end
            ST_CALC1: n_state = ST_CALC2;
            ST_CALC2: n_state = ST_CALC3;
            ST_CALC3: n_state = ST_HDR;
            ST_HDR: begin
                item_valid = 1'b1;
                item.kind  = KIND_HDR;
                if (r_status != STAT_SHORT) begin
                    item.version        = r_d.b0[7:6];
                    item.padding_flag   = r_d.b0[5];
                    item.extension_flag = r_d.b0[4];
                    item.csrc_count     = r_d.b0[3:0];
                    item.marker         = r_d.b1[7];
                    item.payload_type   = r_d.b1[6:0];
                    item.half_field     = r_d.seq;
                    item.word_a         = r_d.ts;
                    item.word_b         = r_d.ssrc;
                end
                if (load_ok) begin
                    n_state = ST_CSRC;
                end
            end
            ST_CSRC: begin
                if (r_left == 4'd0) begin
                    n_state = ST_LAST;
                end else if (!i_word_empty) begin
                    if (emit_csrc) begin
                        item_valid  = 1'b1;
                        item.kind   = KIND_CSRC;
                        item.word_a = i_word;
                        o_word_pop  = load_ok;
                    end else begin
                        // words of a rejected packet are discarded
                        o_word_pop = 1'b1;
                    end
                end
            end
            ST_LAST: begin
                item_valid       = 1'b1;
                item.kind        = KIND_LAYOUT;
                item.half_field  = r_have_prof ? r_d.prof : 16'd0;
                item.word_a      = 32'(r_wa);
                item.word_b      = 32'(r_wb);
                item.last_result = 1'b1;
                if (load_ok) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (item_valid && load_ok) begin
            n_out_valid = 1'b1;
            n_out       = item;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (o_desc_pop) begin
            r_d    <= i_desc;
            r_left <= i_desc.nwords;
        end else if (o_word_pop) begin
            r_left <= r_left - 4'd1;
        end
        case (r_state)
            ST_CALC1: begin
                r_wa        <= '0;
                r_wb        <= '0;
                r_have_prof <= 1'b0;
                r_hfin      <= hlen;
                r_hext      <= hlen + HL_W'(4) + HL_W'({r_d.ewords, 2'b00});
                if (r_d.too_long) begin
                    r_status <= STAT_TOO_LONG;
                end else if (len_x < HL_W'(HDR_FIXED_BYTES)) begin
                    r_status <= STAT_SHORT;
                end else if (hlen > len_x) begin
                    r_status <= STAT_CSRC_CUT;
                end else if (ext && (hlen + HL_W'(4) > len_x)) begin
                    r_status <= STAT_EXT_HDR_CUT;
                end else begin
                    r_status <= STAT_OK;
                end
            end
            ST_CALC2: begin
                if ((r_status == STAT_OK) && ext) begin
                    r_have_prof <= 1'b1;
                    if (r_hext > len_x) begin
                        r_status <= STAT_EXT_DATA_CUT;
                    end else begin
                        r_hfin <= r_hext;
                    end
                end
            end
            ST_CALC3: begin
                if (r_status == STAT_OK) begin
                    // header length is known to fit the packet length here
                    r_wa <= r_hfin[15:0];
                    if (pad && (r_hfin + b_x > len_x)) begin
                        r_status <= STAT_BAD_PAD;
                    end else begin
                        r_wb <= r_d.len - r_hfin[15:0] - (pad ? 16'(r_d.pad_byte) : 16'd0);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

### dv/rhp_checker.sv
// rtp header parser checker: predicts result items from accepted bytes and compares them
module rhp_checker import rhp_pkg::*; #(
    parameter int MAX_PACKET_BYTES = 65535,
    parameter int MAX_CSRC         = 15
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic    i_end_of_packet,
    input  logic    i_out_valid,
    input  logic    i_out_stall,
    input  t_result i_result,
    output int      o_mismatch_count,
    output int      o_items_pending
);

    logic [15:0] byte_cnt;
    logic [15:0] lead_bytes;
    logic [15:0] seq_num;
    logic [31:0] timestamp;
    logic [31:0] ssrc;
    logic [31:0] csrc_words [MAX_CSRC];
    logic [15:0] ext_profile;
    logic [15:0] ext_len_words;

    t_result parsed_items [$];
    int      mismatches = 0;

    task automatic clear_packet();
        byte_cnt      = '0;
        lead_bytes    = '0;
        seq_num       = '0;
        timestamp     = '0;
        ssrc          = '0;
        ext_profile   = '0;
        ext_len_words = '0;
    endtask

    task automatic queue_item(input t_result r);
        parsed_items = {parsed_items, r};
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eop);
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic        over;
        logic        ext;
        logic        pad;
        logic        have_prof;
        logic [2:0]  st;
        int unsigned idx;
        int unsigned hdr;
        int unsigned len;
        int unsigned hlen;
        int unsigned nstore;
        int unsigned wa;
        int unsigned wb;
        int unsigned w;
        t_result     r;

        // byte count saturates, later bytes of an over-long packet are dropped
        over = (byte_cnt >= MAX_PACKET_BYTES);
        idx  = byte_cnt;
        b0   = lead_bytes[15:8];
        if (!over) begin
            hdr = HDR_FIXED_BYTES + 4 * b0[3:0];
            if (idx == 0)
                lead_bytes[15:8] = b;
            else if (idx == 1)
                lead_bytes[7:0] = b;
            else if (idx < 4)
                seq_num = {seq_num[7:0], b};
            else if (idx < 8)
                timestamp = {timestamp[23:0], b};
            else if (idx < 12)
                ssrc = {ssrc[23:0], b};
            else if (idx < hdr) begin
                w = (idx - 12) >> 2;
                if (w < MAX_CSRC)
                    csrc_words[w] = {csrc_words[w][23:0], b};
            end else if (b0[4] && idx < hdr + 4) begin
                if (idx < hdr + 2)
                    ext_profile = {ext_profile[7:0], b};
                else
                    ext_len_words = {ext_len_words[7:0], b};
            end
            byte_cnt = 16'(idx + 1);
        end

        if (eop) begin
            len       = idx + 1;
            b0        = lead_bytes[15:8];
            b1        = lead_bytes[7:0];
            ext       = b0[4];
            pad       = b0[5];
            hlen      = HDR_FIXED_BYTES + 4 * b0[3:0];
            nstore    = (b0[3:0] < MAX_CSRC) ? b0[3:0] : MAX_CSRC;
            have_prof = 1'b0;
            wa        = 0;
            wb        = 0;
            if (over) begin
                st     = STAT_TOO_LONG;
                nstore = 0;
            end else if (len < HDR_FIXED_BYTES) begin
                st     = STAT_SHORT;
                nstore = 0;
            end else if (hlen > len) begin
                st     = STAT_CSRC_CUT;
                nstore = 0;
            end else if (ext && hlen + 4 > len) begin
                st = STAT_EXT_HDR_CUT;
            end else if (ext && hlen + 4 + 4 * ext_len_words > len) begin
                st        = STAT_EXT_DATA_CUT;
                have_prof = 1'b1;
            end else begin
                if (ext) begin
                    hlen      = hlen + 4 + 4 * ext_len_words;
                    have_prof = 1'b1;
                end
                wa = hlen;
                // the final byte is the padding count
                if (pad && hlen + b > len) begin
                    st = STAT_BAD_PAD;
                end else begin
                    st = STAT_OK;
                    wb = len - hlen - (pad ? b : 0);
                end
            end

            r        = '0;
            r.kind   = KIND_HDR;
            r.status = st;
            if (st != STAT_SHORT) begin
                r.version        = b0[7:6];
                r.padding_flag   = b0[5];
                r.extension_flag = b0[4];
                r.csrc_count     = b0[3:0];
                r.marker         = b1[7];
                r.payload_type   = b1[6:0];
                r.half_field     = seq_num;
                r.word_a         = timestamp;
                r.word_b         = ssrc;
            end
            queue_item(r);
            for (int i = 0; i < nstore; i++) begin
                r        = '0;
                r.kind   = KIND_CSRC;
                r.word_a = csrc_words[i];
                r.status = st;
                queue_item(r);
            end
            r             = '0;
            r.kind        = KIND_LAYOUT;
            r.half_field  = have_prof ? ext_profile : 16'd0;
            r.word_a      = wa;
            r.word_b      = wb;
            r.status      = st;
            r.last_result = 1'b1;
            queue_item(r);
            clear_packet();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    task automatic compare_item(input t_result got);
        t_result want;
        if (parsed_items.size() == 0) begin
            $display("%0t: item expected none actual kind %0d word_a 0x%0h status %0d",
                     $time, got.kind, got.word_a, got.status);
            mismatches++;
        end else begin
            want = parsed_items.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("version", want.version, got.version);
            check_field("padding_flag", want.padding_flag, got.padding_flag);
            check_field("extension_flag", want.extension_flag, got.extension_flag);
            check_field("csrc_count", want.csrc_count, got.csrc_count);
            check_field("marker", want.marker, got.marker);
            check_field("payload_type", want.payload_type, got.payload_type);
            check_field("half_field", want.half_field, got.half_field);
            check_field("word_a", want.word_a, got.word_a);
            check_field("word_b", want.word_b, got.word_b);
            check_field("status", want.status, got.status);
            check_field("last_result", want.last_result, got.last_result);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_packet();
            for (int i = 0; i < MAX_CSRC; i++)
                csrc_words[i] = '0;
            parsed_items.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                parse_byte(i_data_byte, i_end_of_packet);
            if (i_out_valid && !i_out_stall)
                compare_item(i_result);
        end
        o_mismatch_count <= mismatches;
        o_items_pending  <= parsed_items.size();
    end

endmodule

### dv/tb_rtp_header_parser.sv
// rtp header parser testbench top: packet stimulus, idle and stall phases, verdict
module tb_rtp_header_parser;
    import rhp_pkg::*;

    localparam int MAX_PKT        = 65535;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_end_of_packet;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_kind;
    logic [1:0]  o_version;
    logic        o_padding_flag;
    logic        o_extension_flag;
    logic [3:0]  o_csrc_count;
    logic        o_marker;
    logic [6:0]  o_payload_type;
    logic [15:0] o_half_field;
    logic [31:0] o_word_a;
    logic [31:0] o_word_b;
    logic [2:0]  o_status;
    logic        o_last_result;

    t_result     seen_item;
    int          mismatch_count;
    int          items_pending;

    logic [7:0]  pkt_bytes [$];
    int          idle_pct;
    int          stall_pct;
    int          quiet_cycles;
    int          pkt_total;
    int          byte_total;

    assign seen_item = {o_kind, o_version, o_padding_flag, o_extension_flag, o_csrc_count,
                        o_marker, o_payload_type, o_half_field, o_word_a, o_word_b,
                        o_status, o_last_result};

    rtp_header_parser #(
        .MAX_PACKET_BYTES(MAX_PKT),
        .MAX_CSRC        (15)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_packet (i_end_of_packet),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_version       (o_version),
        .o_padding_flag  (o_padding_flag),
        .o_extension_flag(o_extension_flag),
        .o_csrc_count    (o_csrc_count),
        .o_marker        (o_marker),
        .o_payload_type  (o_payload_type),
        .o_half_field    (o_half_field),
        .o_word_a        (o_word_a),
        .o_word_b        (o_word_b),
        .o_status        (o_status),
        .o_last_result   (o_last_result)
    );

    rhp_checker #(
        .MAX_PACKET_BYTES(MAX_PKT),
        .MAX_CSRC        (15)
    ) parse_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_end_of_packet (i_end_of_packet),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_result        (seen_item),
        .o_mismatch_count(mismatch_count),
        .o_items_pending (items_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // ends the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic set_phase(input int p);
        case (p)
            0: begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            1: begin
                idle_pct  = 85;
                stall_pct = 0;
            end
            2: begin
                idle_pct  = 0;
                stall_pct = 85;
            end
            default: begin
                idle_pct  = 8;
                stall_pct = 8;
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eop);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_end_of_packet <= eop;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // each packet runs under the next idle and stall phase in turn
    task automatic send_packet();
        set_phase(pkt_total % 4);
        for (int i = 0; i < pkt_bytes.size(); i++)
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
        pkt_total++;
        byte_total += pkt_bytes.size();
    endtask

    task automatic add_byte(input logic [7:0] b);
        pkt_bytes = {pkt_bytes, b};
    endtask

    // packet with random content, well-formed unless padding is set with no payload
    task automatic build_packet(input int cc, input bit ext, input bit pad,
                                input int ewords, input int payload);
        logic [1:0] ver;
        ver = ($urandom_range(3) == 0) ? 2'($urandom) : 2'd2;
        pkt_bytes.delete();
        add_byte({ver, pad, ext, 4'(cc)});
        for (int i = 1; i < 12 + 4 * cc; i++)
            add_byte(8'($urandom));
        if (ext) begin
            add_byte(8'($urandom));
            add_byte(8'($urandom));
            add_byte(8'(ewords >> 8));
            add_byte(8'(ewords));
            for (int i = 0; i < 4 * ewords; i++)
                add_byte(8'($urandom));
        end
        for (int i = 0; i < payload; i++)
            add_byte(8'($urandom));
        if (pad && payload > 0)
            pkt_bytes[pkt_bytes.size() - 1] = 8'($urandom_range(payload > 255 ? 255 : payload));
    endtask

    task automatic trim_packet(input int n);
        while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
    endtask

    task automatic fill_packet(input int n, input logic [7:0] b);
        pkt_bytes.delete();
        repeat (n) add_byte(b);
    endtask

    task automatic make_random_packet();
        int sel;
        int cc;
        sel = $urandom_range(99);
        cc  = $urandom_range(2);
        build_packet(cc, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(2),
                     $urandom_range(12));
        if (sel < 12) begin
            trim_packet($urandom_range(1, pkt_bytes.size()));
        end else if (sel < 20) begin
            // padding count larger than what follows the header
            pkt_bytes[0] = pkt_bytes[0] | 8'h20;
            pkt_bytes[pkt_bytes.size() - 1] = 8'hFF;
        end else if (sel < 28) begin
            pkt_bytes.delete();
            repeat ($urandom_range(1, 24)) add_byte(8'($urandom));
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_data_byte     = '0;
        i_end_of_packet = 1'b0;
        pkt_total       = 0;
        byte_total      = 0;
        set_phase(0);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single byte and eleven byte packets are short
        fill_packet(1, 8'hFF);
        send_packet();
        fill_packet(11, 8'hFF);
        send_packet();
        // all ones announces 15 csrc words that never come
        fill_packet(12, 8'hFF);
        send_packet();
        // full set of csrc words, the longest burst of result items
        build_packet(15, 0, 0, 0, 0);
        send_packet();
        // extension header cut after its profile
        build_packet(0, 1, 0, 0, 0);
        trim_packet(14);
        send_packet();
        // extension data cut
        build_packet(0, 1, 0, 1, 0);
        trim_packet(17);
        send_packet();
        // padding count of zero, then one larger than the packet
        build_packet(0, 0, 1, 0, 1);
        pkt_bytes[pkt_bytes.size() - 1] = 8'h00;
        send_packet();
        build_packet(0, 0, 1, 0, 1);
        pkt_bytes[pkt_bytes.size() - 1] = 8'hFF;
        send_packet();

        while (byte_total < 180) begin
            make_random_packet();
            send_packet();
        end

        i_in_valid <= 1'b0;
        set_phase(0);
        @(posedge i_clk);
        while (items_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d packets (%0d bytes): short, cut csrc/extension and padding",
                 pkt_total, byte_total);
        $display("cases plus random packets, rotating through sender idle and receiver stall");
        if (mismatch_count == 0 && items_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
